// File: sv/luhn_pkg.sv
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared widths, verdict codes and issuer classification for the Luhn checker.
// ----------------------------------------------------------------------------
package luhn_pkg;

    localparam int NUM_W        = 63;
    localparam int NUM_DIGITS   = 19;
    localparam int BCD_W        = NUM_DIGITS * 4;
    localparam int MAX_DIGITS_D = 19;
    localparam int VERDICT_W    = 3;
    localparam int LEAD_W       = 7;
    localparam int SUM_W        = 8;

    localparam logic [NUM_W-1:0] MIN_NUMBER_RESET = 63'd1000000000000;

    localparam logic [VERDICT_W-1:0] V_SHORT     = 3'd0;
    localparam logic [VERDICT_W-1:0] V_BADSUM    = 3'd1;
    localparam logic [VERDICT_W-1:0] V_BADPREFIX = 3'd2;
    localparam logic [VERDICT_W-1:0] V_AMEX      = 3'd3;
    localparam logic [VERDICT_W-1:0] V_MASTER    = 3'd4;
    localparam logic [VERDICT_W-1:0] V_VISA      = 3'd5;

    localparam logic [LEAD_W-1:0] LEAD_AMEX_A   = 7'd34;
    localparam logic [LEAD_W-1:0] LEAD_AMEX_B   = 7'd37;
    localparam logic [LEAD_W-1:0] LEAD_MC_LO    = 7'd51;
    localparam logic [LEAD_W-1:0] LEAD_MC_HI    = 7'd55;
    localparam logic [LEAD_W-1:0] LEAD_VISA_LO  = 7'd40;
    localparam logic [LEAD_W-1:0] LEAD_VISA_HI  = 7'd49;

    function automatic logic [VERDICT_W-1:0] classify(
        input logic              too_short,
        input logic              sum_ok,
        input logic [LEAD_W-1:0] lead
    );
        logic [VERDICT_W-1:0] v;
        if (too_short)
            v = V_SHORT;
        else if (!sum_ok)
            v = V_BADSUM;
        else if (lead == LEAD_AMEX_A || lead == LEAD_AMEX_B)
            v = V_AMEX;
        else if (lead >= LEAD_MC_LO && lead <= LEAD_MC_HI)
            v = V_MASTER;
        else if (lead >= LEAD_VISA_LO && lead <= LEAD_VISA_HI)
            v = V_VISA;
        else
            v = V_BADPREFIX;
        return v;
    endfunction

endpackage

// File: sv/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check
// Luhn mod 10 check and issuer classification of a binary card number.
// Processing: the bit-serial double dabble (one bit per cycle) is followed by
// the digit scan (one BCD digit per cycle); in_stall holds off a new number
// until the result is loaded into the output register.
// Reset: control state cleared, min_number returns to 1000000000000.
// ----------------------------------------------------------------------------
module luhn_card_number_check #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [luhn_pkg::NUM_W-1:0]        card_number,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [luhn_pkg::VERDICT_W-1:0]    verdict,
    output logic [luhn_pkg::LEAD_W-1:0]       leading_digits,
    output logic [luhn_pkg::SUM_W-1:0]        luhn_sum,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [luhn_pkg::NUM_W-1:0]        min_number
);

    localparam int BIT_CNT_W = $clog2(luhn_pkg::NUM_W);
    localparam int DIG_CNT_W = $clog2(luhn_pkg::NUM_DIGITS);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(luhn_pkg::NUM_W - 1);
    localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(luhn_pkg::NUM_DIGITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;
    logic [luhn_pkg::NUM_W-1:0]         min_number_reg, min_number_next;
    logic [luhn_pkg::NUM_W-1:0]         bin_reg, bin_next;
    logic [luhn_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]               bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]               dig_cnt_reg, dig_cnt_next;
    logic [3:0]                         prev_reg, prev_next;
    logic [luhn_pkg::LEAD_W-1:0]        lead_reg, lead_next;
    logic [luhn_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [3:0]                         mod_reg, mod_next;
    logic                               short_reg, short_next;
    logic                               out_valid_reg, out_valid_next;
    logic [luhn_pkg::VERDICT_W-1:0]     verdict_reg, verdict_next;
    logic [luhn_pkg::LEAD_W-1:0]        lead_out_reg, lead_out_next;
    logic [luhn_pkg::SUM_W-1:0]         sum_out_reg, sum_out_next;

    logic [luhn_pkg::BCD_W-1:0]         bcd_adj;
    logic [3:0]                         digit;
    logic [4:0]                         dbl;
    logic [3:0]                         term;
    logic [4:0]                         mod_sum;
    logic                               in_xfer;

    assign in_stall       = (state_reg != ST_IDLE);
    assign in_xfer        = in_valid && !in_stall;
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign leading_digits = lead_out_reg;
    assign luhn_sum       = sum_out_reg;

    // add-3 correction on every BCD digit
    always_comb
    begin
        for (int i = 0; i < luhn_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // Luhn term of the current digit
    always_comb
    begin
        digit = bcd_reg[3:0];
        dbl   = {digit, 1'b0};
        if (!dig_cnt_reg[0])
            term = digit;
        else if (dbl > 5'd9)
            term = 4'(dbl - 5'd9);
        else
            term = dbl[3:0];
        if (32'(dig_cnt_reg) >= MAX_DIGITS)
            term = 4'd0;
        mod_sum = {1'b0, mod_reg} + {1'b0, term};
    end

    always_comb
    begin
        state_next      = state_reg;
        min_number_next = min_number_reg;
        bin_next        = bin_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        prev_next       = prev_reg;
        lead_next       = lead_reg;
        sum_next        = sum_reg;
        mod_next        = mod_reg;
        short_next      = short_reg;
        out_valid_next  = out_valid_reg;
        verdict_next    = verdict_reg;
        lead_out_next   = lead_out_reg;
        sum_out_next    = sum_out_reg;

        if (cfg_valid && cfg_ready)
            min_number_next = min_number;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    bin_next     = card_number;
                    short_next   = (card_number < min_number_reg);
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[luhn_pkg::BCD_W-2:0], bin_reg[luhn_pkg::NUM_W-1]};
                bin_next     = {bin_reg[luhn_pkg::NUM_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    dig_cnt_next = '0;
                    prev_next    = '0;
                    lead_next    = '0;
                    sum_next     = '0;
                    mod_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                bcd_next     = {4'd0, bcd_reg[luhn_pkg::BCD_W-1:4]};
                dig_cnt_next = dig_cnt_reg + 1'b1;
                prev_next    = digit;
                sum_next     = sum_reg + luhn_pkg::SUM_W'(term);
                mod_next     = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];
                if (digit != 4'd0)
                begin
                    if (dig_cnt_reg == '0)
                        lead_next = luhn_pkg::LEAD_W'(digit);
                    else
                        lead_next = luhn_pkg::LEAD_W'(digit) * 7'd10
                                    + luhn_pkg::LEAD_W'(prev_reg);
                end
                if (dig_cnt_reg == DIG_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = luhn_pkg::classify(short_reg, mod_reg == 4'd0, lead_reg);
                    lead_out_next  = lead_reg;
                    sum_out_next   = sum_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_number_reg <= luhn_pkg::MIN_NUMBER_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_number_reg <= min_number_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        prev_reg     <= prev_next;
        lead_reg     <= lead_next;
        sum_reg      <= sum_next;
        mod_reg      <= mod_next;
        short_reg    <= short_next;
        verdict_reg  <= verdict_next;
        lead_out_reg <= lead_out_next;
        sum_out_reg  <= sum_out_next;
    end

    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_CONV)
        else $error("accepted number did not start conversion");

    a_amex_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == luhn_pkg::V_AMEX
            |-> leading_digits == 7'd34 || leading_digits == 7'd37)
        else $error("amex verdict with wrong prefix");

    a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> leading_digits <= 7'd99 && luhn_sum <= 8'd171)
        else $error("result out of range");

    a_mod_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> mod_reg <= 4'd9)
        else $error("running mod 10 out of range");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !out_valid_reg |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not loaded into free output register");

endmodule
